### rtl/scr_pkg.sv
// Shared types, widths and register codes of the segment/portal crossing block.
package scr_pkg;

   // Item and register widths
   localparam int COORD_W       = 32;
   localparam int DIR_COMP_BITS = 21;
   localparam int DIR_W         = 3 * DIR_COMP_BITS;
   localparam int SIZE_W        = 31;
   localparam int SIZE_REG_W    = 2 * SIZE_W;
   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_IDX_LSB   = 3;

   // Axis normalization
   localparam int NORM_TOP  = 19;
   localparam int UNIT_BITS = 30;
   localparam int SQ_PAD    = 10;
   localparam int UNIT_W    = UNIT_BITS + 2;
   localparam int LEN_W     = UNIT_BITS + 1;
   localparam int SQ_W      = 2 * DIR_COMP_BITS;
   localparam int SUMSQ_W   = SQ_W + 2;
   localparam int RAD_W     = SUMSQ_W + 2 * SQ_PAD;
   localparam int ROOT_IT_W = 5;
   localparam int NUM_W     = DIR_COMP_BITS + UNIT_BITS + SQ_PAD;
   localparam int REM_W     = NUM_W + 1;

   // Datapath
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = DIFF_W + UNIT_W;
   localparam int TERM_W  = PROD_W - UNIT_BITS;
   localparam int DOT_W   = TERM_W + 2;
   localparam int MAG_W   = DOT_W;
   localparam int DEN_W   = MAG_W + 1;
   localparam int T_BITS  = 28;
   localparam int LERP_W  = DOT_W + 1 + T_BITS + 1;
   localparam int STEP_W  = LERP_W - T_BITS;
   localparam int POS_W   = STEP_W + 1;

   typedef enum logic [2:0] {
      REG_CENTRE_X    = 3'd0,
      REG_CENTRE_Y    = 3'd1,
      REG_CENTRE_Z    = 3'd2,
      REG_NORMAL_DIR  = 3'd3,
      REG_RIGHT_DIR   = 3'd4,
      REG_UP_DIR      = 3'd5,
      REG_SIZE_WH     = 3'd6,
      REG_SIDE_MARGIN = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [COORD_W-1:0]    centre_x;
      logic [COORD_W-1:0]    centre_y;
      logic [COORD_W-1:0]    centre_z;
      logic [DIR_W-1:0]      normal_dir;
      logic [DIR_W-1:0]      right_dir;
      logic [DIR_W-1:0]      up_dir;
      logic [SIZE_REG_W-1:0] size_wh;
      logic [SIZE_W-1:0]     side_margin;
   } cfg_type;

   // Three unit axes (normal, right, up), three components each, Q1.30
   typedef logic [2:0][UNIT_W-1:0] axis_type;
   typedef axis_type [2:0]          frame_type;

   // Item data that rides alongside the divider
   typedef struct packed {
      logic                    beyond;
      logic signed [DOT_W-1:0] rp;
      logic signed [DOT_W:0]   dr;
      logic signed [DOT_W-1:0] up;
      logic signed [DOT_W:0]   du;
   } side_type;

endpackage

### rtl/scr_if.sv
// Item channel interfaces: segment request and crossing response.
interface scr_req_if;
   import scr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] prev_x;
   logic signed [COORD_W-1:0] prev_y;
   logic signed [COORD_W-1:0] prev_z;
   logic signed [COORD_W-1:0] cur_x;
   logic signed [COORD_W-1:0] cur_y;
   logic signed [COORD_W-1:0] cur_z;
   modport source (output valid, prev_x, prev_y, prev_z, cur_x, cur_y, cur_z, input ready);
   modport sink (input valid, prev_x, prev_y, prev_z, cur_x, cur_y, cur_z, output ready);
endinterface

interface scr_rsp_if;
   logic valid;
   logic ready;
   logic crosses;
   modport source (output valid, crosses, input ready);
   modport sink (input valid, crosses, output ready);
endinterface

### rtl/scr_csr.sv
// Configuration register file behind the APB-style port.
module scr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [scr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [scr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [scr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output scr_pkg::cfg_type                 cfg,
   output logic                             dir_wr
);
   import scr_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr;

   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:CSR_IDX_LSB]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      dir_wr = 1'b0;
      if (wr) begin
         unique case (idx)
            REG_CENTRE_X:    cfg_in.centre_x    = pwdata[COORD_W-1:0];
            REG_CENTRE_Y:    cfg_in.centre_y    = pwdata[COORD_W-1:0];
            REG_CENTRE_Z:    cfg_in.centre_z    = pwdata[COORD_W-1:0];
            REG_NORMAL_DIR: begin
               cfg_in.normal_dir = pwdata[DIR_W-1:0];
               dir_wr = 1'b1;
            end
            REG_RIGHT_DIR: begin
               cfg_in.right_dir = pwdata[DIR_W-1:0];
               dir_wr = 1'b1;
            end
            REG_UP_DIR: begin
               cfg_in.up_dir = pwdata[DIR_W-1:0];
               dir_wr = 1'b1;
            end
            REG_SIZE_WH:     cfg_in.size_wh     = pwdata[SIZE_REG_W-1:0];
            REG_SIDE_MARGIN: cfg_in.side_margin = pwdata[SIZE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_CENTRE_X:    prdata = CSR_DATA_W'(cfg_ff.centre_x);
         REG_CENTRE_Y:    prdata = CSR_DATA_W'(cfg_ff.centre_y);
         REG_CENTRE_Z:    prdata = CSR_DATA_W'(cfg_ff.centre_z);
         REG_NORMAL_DIR:  prdata = CSR_DATA_W'(cfg_ff.normal_dir);
         REG_RIGHT_DIR:   prdata = CSR_DATA_W'(cfg_ff.right_dir);
         REG_UP_DIR:      prdata = CSR_DATA_W'(cfg_ff.up_dir);
         REG_SIZE_WH:     prdata = CSR_DATA_W'(cfg_ff.size_wh);
         REG_SIDE_MARGIN: prdata = CSR_DATA_W'(cfg_ff.side_margin);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/scr_norm.sv
// Sequential axis normalizer: scale, sum of squares, bit-serial root, restoring divide.
module scr_norm (
   input  logic               clock,
   input  logic               reset,
   input  scr_pkg::cfg_type   cfg,
   input  logic               dir_wr,
   output scr_pkg::frame_type unit,
   output logic               busy
);
   import scr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_SHIFT, ST_SQUARE, ST_SQRT, ST_DIV
   } state_type;

   state_type                              state_ff, state_in;
   logic                                   pend_ff, pend_in;
   logic [1:0]                             ax_ff, ax_in;
   logic [1:0]                             k_ff, k_in;
   logic [ROOT_IT_W-1:0]                   it_ff, it_in;
   logic [2:0][DIR_COMP_BITS-1:0]          mag_ff, mag_in;
   logic [2:0]                             neg_ff, neg_in;
   logic [SUMSQ_W-1:0]                     sum_ff, sum_in;
   logic [RAD_W-1:0]                       x_ff, x_in;
   logic [RAD_W-1:0]                       r_ff, r_in;
   logic [REM_W-1:0]                       rem_ff, rem_in;
   logic [LEN_W-1:0]                       q_ff, q_in;
   frame_type                              unit_ff, unit_in;

   logic [DIR_W-1:0]                       packed_dir;
   logic [2:0][DIR_COMP_BITS-1:0]          comp;
   logic [DIR_COMP_BITS-1:0]               any_mag;
   logic [SUMSQ_W-1:0]                     sum_nx;
   logic [RAD_W-1:0]                       root_bit;
   logic [RAD_W-1:0]                       root_try;
   logic [REM_W-1:0]                       div_try;
   logic [LEN_W-1:0]                       q_nx;
   logic [UNIT_W-1:0]                      q_ext;

   assign unit = unit_ff;
   assign busy = (state_ff != ST_IDLE) | pend_ff;

   always_comb begin
      unique case (ax_ff)
         2'd0:    packed_dir = cfg.normal_dir;
         2'd1:    packed_dir = cfg.right_dir;
         default: packed_dir = cfg.up_dir;
      endcase
      for (int i = 0; i < 3; i++) begin
         comp[i] = packed_dir[i*DIR_COMP_BITS +: DIR_COMP_BITS];
      end
   end

   assign any_mag  = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign sum_nx   = sum_ff + SUMSQ_W'(mag_ff[k_ff] * mag_ff[k_ff]);
   assign root_bit = RAD_W'(1) << {it_ff, 1'b0};
   assign root_try = r_ff + root_bit;
   assign div_try  = REM_W'(r_ff[LEN_W-1:0]) << it_ff;
   assign q_nx     = (rem_ff >= div_try) ? (q_ff | (LEN_W'(1) << it_ff)) : q_ff;
   assign q_ext    = UNIT_W'(q_nx);

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      ax_in    = ax_ff;
      k_in     = k_ff;
      it_in    = it_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      sum_in   = sum_ff;
      x_in     = x_ff;
      r_in     = r_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      unit_in  = unit_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pend_ff) begin
               pend_in  = 1'b0;
               ax_in    = 2'd0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = comp[i][DIR_COMP_BITS-1];
               mag_in[i] = comp[i][DIR_COMP_BITS-1] ? -comp[i] : comp[i];
            end
            if (comp == '0) begin
               // zero axis: zero vector
               unit_in[ax_ff] = '0;
               if (ax_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (any_mag[DIR_COMP_BITS-1:NORM_TOP] == '0) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = {mag_ff[i][DIR_COMP_BITS-2:0], 1'b0};
               end
            end else begin
               sum_in   = '0;
               k_in     = 2'd0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sum_in = sum_nx;
            if (k_ff == 2'd2) begin
               x_in     = {sum_nx, (2 * SQ_PAD)'(0)};
               r_in     = '0;
               it_in    = '1;
               state_in = ST_SQRT;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_SQRT: begin
            if (x_ff >= root_try) begin
               x_in = x_ff - root_try;
               r_in = (r_ff >> 1) + root_bit;
            end else begin
               r_in = r_ff >> 1;
            end
            if (it_ff == '0) begin
               k_in     = 2'd0;
               rem_in   = REM_W'({mag_ff[0], (UNIT_BITS + SQ_PAD)'(0)});
               q_in     = '0;
               it_in    = ROOT_IT_W'(LEN_W - 1);
               state_in = ST_DIV;
            end else begin
               it_in = it_ff - ROOT_IT_W'(1);
            end
         end
         ST_DIV: begin
            q_in = q_nx;
            if (rem_ff >= div_try) begin
               rem_in = rem_ff - div_try;
            end
            if (it_ff == '0) begin
               unit_in[ax_ff][k_ff] = neg_ff[k_ff] ? -q_ext : q_ext;
               if (k_ff == 2'd2) begin
                  if (ax_ff == 2'd2) begin
                     state_in = ST_IDLE;
                  end else begin
                     ax_in    = ax_ff + 2'd1;
                     state_in = ST_LOAD;
                  end
               end else begin
                  k_in   = k_ff + 2'd1;
                  rem_in = REM_W'({mag_ff[k_ff + 2'd1], (UNIT_BITS + SQ_PAD)'(0)});
                  q_in   = '0;
                  it_in  = ROOT_IT_W'(LEN_W - 1);
               end
            end else begin
               it_in = it_ff - ROOT_IT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a direction write during a run queues another run after it
      if (dir_wr) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         unit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         unit_ff  <= unit_in;
      end
      ax_ff  <= ax_in;
      k_ff   <= k_in;
      it_ff  <= it_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      sum_ff <= sum_in;
      x_ff   <= x_in;
      r_ff   <= r_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

endmodule

### rtl/scr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with item data alongside.
module scr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [scr_pkg::MAG_W-1:0]     num,
   input  logic [scr_pkg::DEN_W-1:0]     den,
   input  scr_pkg::side_type             side_in,
   output logic                          out_valid,
   output logic [scr_pkg::T_BITS-1:0]    quot,
   output scr_pkg::side_type             side_out
);
   import scr_pkg::*;

   logic                 valid_ff [T_BITS];
   logic [DEN_W-1:0]     rem_ff   [T_BITS];
   logic [DEN_W-1:0]     den_ff   [T_BITS];
   logic [T_BITS-1:0]    q_ff     [T_BITS];
   side_type             side_ff  [T_BITS];

   logic                 valid_src [T_BITS];
   logic [DEN_W-1:0]     rem_src   [T_BITS];
   logic [DEN_W-1:0]     den_src   [T_BITS];
   logic [T_BITS-1:0]    q_src     [T_BITS];
   side_type             side_src  [T_BITS];
   logic [DEN_W:0]       two_rem   [T_BITS];
   logic                 take      [T_BITS];

   always_comb begin
      for (int g = 0; g < T_BITS; g++) begin
         if (g == 0) begin
            valid_src[g] = in_valid;
            rem_src[g]   = DEN_W'(num);
            den_src[g]   = den;
            q_src[g]     = '0;
            side_src[g]  = side_in;
         end else begin
            valid_src[g] = valid_ff[g-1];
            rem_src[g]   = rem_ff[g-1];
            den_src[g]   = den_ff[g-1];
            q_src[g]     = q_ff[g-1];
            side_src[g]  = side_ff[g-1];
         end
         two_rem[g] = {rem_src[g], 1'b0};
         take[g]    = two_rem[g] >= {1'b0, den_src[g]};
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < T_BITS; g++) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_src[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < T_BITS; g++) begin
            rem_ff[g]  <= take[g] ? DEN_W'(two_rem[g] - {1'b0, den_src[g]})
                                  : two_rem[g][DEN_W-1:0];
            den_ff[g]  <= den_src[g];
            q_ff[g]    <= {q_src[g][T_BITS-2:0], take[g]};
            side_ff[g] <= side_src[g];
         end
      end
   end

   assign out_valid = valid_ff[T_BITS-1];
   assign quot      = q_ff[T_BITS-1];
   assign side_out  = side_ff[T_BITS-1];

endmodule

### rtl/segment_rectangle_crossing.sv
// Top level: segment versus rectangular portal crossing test, fully pipelined.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------
//   req     | in        | valid/ready                | prev_x/y/z, cur_x/y/z (Q16.16)
//   rsp     | out       | valid/ready                | crosses
//   csr     | in        | APB psel/penable, pready=1 | 8 regs at 8*i, 64-bit data
//
// One item per cycle while neither a full output buffer nor the normalizer holds req.ready low.
// The depth is set by the 28-stage quotient pipeline for the hit parameter t.
// After a write to normal_dir, right_dir or up_dir the axis normalizer runs
// (a 32-step root per axis, a 31-step divide per component) and req.ready stays low.
// A two-entry output buffer takes results; the pipeline stalls as a whole only
// when it is full, and a stall loses or repeats nothing. Reset is synchronous.
module segment_rectangle_crossing (
   input  logic                           clock,
   input  logic                           reset,
   scr_req_if.sink                        req,
   scr_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [scr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [scr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [scr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import scr_pkg::*;

   cfg_type   cfg;
   logic      dir_wr;
   frame_type unit;
   logic      norm_busy;
   logic      en;

   scr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .dir_wr  (dir_wr)
   );

   scr_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .dir_wr (dir_wr),
      .unit   (unit),
      .busy   (norm_busy)
   );

   // ---------------------------------------------------------------
   // Stage 1: offsets of both ends from the portal centre
   // ---------------------------------------------------------------
   logic signed [COORD_W-1:0] pt     [2][3];
   logic signed [COORD_W-1:0] ctr    [3];
   logic                      s1_valid_ff;
   logic signed [DIFF_W-1:0]  s1_d_ff [2][3];
   logic signed [DIFF_W-1:0]  s1_d_in [2][3];

   assign req.ready = en & ~norm_busy;

   always_comb begin
      pt[0][0] = req.prev_x;
      pt[0][1] = req.prev_y;
      pt[0][2] = req.prev_z;
      pt[1][0] = req.cur_x;
      pt[1][1] = req.cur_y;
      pt[1][2] = req.cur_z;
      ctr[0]   = $signed(cfg.centre_x);
      ctr[1]   = $signed(cfg.centre_y);
      ctr[2]   = $signed(cfg.centre_z);
      for (int e = 0; e < 2; e++) begin
         for (int k = 0; k < 3; k++) begin
            s1_d_in[e][k] = DIFF_W'(pt[e][k]) - DIFF_W'(ctr[k]);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: eighteen products with the unit axes, floor by 2^30
   // ---------------------------------------------------------------
   logic                      s2_valid_ff;
   logic signed [TERM_W-1:0]  s2_term_ff [3][2][3];
   logic signed [TERM_W-1:0]  s2_term_in [3][2][3];
   logic signed [PROD_W-1:0]  prod       [3][2][3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int e = 0; e < 2; e++) begin
            for (int k = 0; k < 3; k++) begin
               prod[a][e][k] = s1_d_ff[e][k] * $signed(unit[a][k]);
               s2_term_in[a][e][k] = prod[a][e][k][PROD_W-1:UNIT_BITS];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: dot products (axis, end)
   // ---------------------------------------------------------------
   logic                      s3_valid_ff;
   logic signed [DOT_W-1:0]   s3_dot_ff [3][2];
   logic signed [DOT_W-1:0]   s3_dot_in [3][2];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int e = 0; e < 2; e++) begin
            s3_dot_in[a][e] = DOT_W'(s2_term_ff[a][e][0]) + DOT_W'(s2_term_ff[a][e][1])
                            + DOT_W'(s2_term_ff[a][e][2]);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: side test, distance magnitudes, projection deltas
   // ---------------------------------------------------------------
   logic signed [DOT_W-1:0] dist_a, dist_b, eps;
   logic [MAG_W-1:0]        ma_in, mb_in;
   side_type                s4_side_in;
   logic                    s4_valid_ff;
   logic [MAG_W-1:0]        s4_ma_ff;
   logic [DEN_W-1:0]        s4_den_ff;
   side_type                s4_side_ff;

   always_comb begin
      dist_a = s3_dot_ff[0][0];
      dist_b = s3_dot_ff[0][1];
      eps    = $signed(DOT_W'(cfg.side_margin));
      ma_in  = dist_a[DOT_W-1] ? MAG_W'(-dist_a) : MAG_W'(dist_a);
      mb_in  = dist_b[DOT_W-1] ? MAG_W'(-dist_b) : MAG_W'(dist_b);
      // strictly beyond the margin on opposite sides
      s4_side_in.beyond = ((dist_a > eps) && (dist_b < -eps))
                       || ((dist_a < -eps) && (dist_b > eps));
      s4_side_in.rp = s3_dot_ff[1][0];
      s4_side_in.dr = (DOT_W+1)'(s3_dot_ff[1][1]) - (DOT_W+1)'(s3_dot_ff[1][0]);
      s4_side_in.up = s3_dot_ff[2][0];
      s4_side_in.du = (DOT_W+1)'(s3_dot_ff[2][1]) - (DOT_W+1)'(s3_dot_ff[2][0]);
   end

   // ---------------------------------------------------------------
   // Divider: t = floor(|a| * 2^28 / (|a| + |b|))
   // ---------------------------------------------------------------
   logic              dv_valid;
   logic [T_BITS-1:0] dv_t;
   side_type          dv_side;

   scr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .num       (s4_ma_ff),
      .den       (s4_den_ff),
      .side_in   (s4_side_ff),
      .out_valid (dv_valid),
      .quot      (dv_t),
      .side_out  (dv_side)
   );

   // ---------------------------------------------------------------
   // Stage 5: scale the projection deltas by t
   // ---------------------------------------------------------------
   logic                      s5_valid_ff;
   logic signed [LERP_W-1:0]  s5_px_ff, s5_py_ff;
   logic signed [DOT_W-1:0]   s5_rp_ff, s5_up_ff;
   logic                      s5_cross_ff;
   logic signed [T_BITS:0]    t_s;

   assign t_s = $signed({1'b0, dv_t});

   // ---------------------------------------------------------------
   // Final: interpolated coordinates and the half-extent check
   // ---------------------------------------------------------------
   logic signed [POS_W-1:0] lx, ly;
   logic [POS_W-1:0]        mx, my;
   logic [POS_W:0]          wx2, hy2;
   logic                    hit;

   always_comb begin
      // floor of the scaled delta keeps its sign
      lx  = POS_W'(s5_rp_ff) + POS_W'($signed(s5_px_ff[LERP_W-1:T_BITS]));
      ly  = POS_W'(s5_up_ff) + POS_W'($signed(s5_py_ff[LERP_W-1:T_BITS]));
      mx  = lx[POS_W-1] ? POS_W'(-lx) : POS_W'(lx);
      my  = ly[POS_W-1] ? POS_W'(-ly) : POS_W'(ly);
      wx2 = {mx, 1'b0};
      hy2 = {my, 1'b0};
      hit = s5_cross_ff
          && (wx2 <= (POS_W+1)'(cfg.size_wh[SIZE_W-1:0]))
          && (hy2 <= (POS_W+1)'(cfg.size_wh[SIZE_REG_W-1:SIZE_W]));
   end

   // ---------------------------------------------------------------
   // Pipeline registers: valid bits reset, payload advances with en
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req.valid & req.ready;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_d_ff     <= s1_d_in;
         s2_term_ff  <= s2_term_in;
         s3_dot_ff   <= s3_dot_in;
         s4_ma_ff    <= ma_in;
         s4_den_ff   <= DEN_W'(ma_in) + DEN_W'(mb_in);
         s4_side_ff  <= s4_side_in;
         s5_px_ff    <= dv_side.dr * t_s;
         s5_py_ff    <= dv_side.du * t_s;
         s5_rp_ff    <= dv_side.rp;
         s5_up_ff    <= dv_side.up;
         s5_cross_ff <= dv_side.beyond;
      end
   end

   // ---------------------------------------------------------------
   // Output buffer: two entries; hold the pipeline only when full
   // ---------------------------------------------------------------
   logic       obuf_ff [2];
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   logic       wr_idx;

   assign en          = (cnt_ff != 2'd2);
   assign push        = en & s5_valid_ff;
   assign pop         = rsp.valid & rsp.ready;
   assign wr_idx      = rd_ff ^ cnt_ff[0];
   assign rsp.valid   = (cnt_ff != 2'd0);
   assign rsp.crosses = obuf_ff[rd_ff];

   always_comb begin
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         obuf_ff[wr_idx] <= hit;
      end
   end

endmodule

### verif/tb.sv
// Testbench for the segment/portal crossing block: predicts each result and checks it.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scr_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // APB-style register port
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   scr_req_if req ();
   scr_rsp_if rsp ();

   segment_rectangle_crossing i_dut (
      .clock  (clock),
      .reset  (reset),
      .req    (req.sink),
      .rsp    (rsp.source),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Expected crossing flags, oldest first
   bit crossing_q [$];
   int mismatches = 0;
   bit hold_off = 1'b0;

   // Local copy of the portal registers
   logic [31:0] centre [3];
   logic [62:0] axis_reg [3];   // normal, right, up
   logic [61:0] size_wh;
   logic [30:0] margin;

   initial begin
      req.valid = 1'b0;
      req.prev_x = '0; req.prev_y = '0; req.prev_z = '0;
      req.cur_x = '0;  req.cur_y = '0;  req.cur_z = '0;
      rsp.ready = 1'b0;
      foreach (centre[i]) centre[i] = '0;
      foreach (axis_reg[i]) axis_reg[i] = '0;
      size_wh = '0;
      margin = '0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   // Normalize one packed axis to Q1.30; an all-zero axis stays zero
   function automatic void unit_axis(logic [62:0] p, output longint u [3]);
      logic signed [20:0] comp;
      longint c [3];
      logic [63:0] mag [3];
      logic [63:0] m;
      logic [63:0] s;
      logic [63:0] len;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         comp = p[i*DIR_COMP_BITS +: DIR_COMP_BITS];
         c[i] = comp;
         mag[i] = c[i] < 0 ? -c[i] : c[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         foreach (u[i]) u[i] = 0;
         return;
      end
      while (m < (64'd1 << NORM_TOP)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
      len = int_sqrt(s << (2 * SQ_PAD));
      for (int i = 0; i < 3; i++) begin
         u[i] = longint'((mag[i] << (UNIT_BITS + SQ_PAD)) / len);
         if (c[i] < 0) u[i] = -u[i];
      end
   endfunction

   function automatic longint project(longint d [3], longint u [3]);
      longint sum;
      sum = 0;
      for (int i = 0; i < 3; i++) sum += (d[i] * u[i]) >>> UNIT_BITS;
      return sum;
   endfunction

   function automatic longint lerp(longint rp, longint rc, logic signed [127:0] t);
      logic signed [127:0] step;
      step = rc - rp;
      step = (step * t) >>> T_BITS;
      return rp + longint'(step);
   endfunction

   function automatic bit fits(longint q, logic [30:0] extent);
      logic [63:0] mq;
      mq = q < 0 ? -q : q;
      return (2 * mq) <= {33'd0, extent};
   endfunction

   function automatic bit predict_crossing(logic signed [31:0] pt [6]);
      longint dp [3];
      longint dc [3];
      longint nu [3];
      longint ru [3];
      longint uu [3];
      longint a, b, eps, lx, ly;
      logic [127:0] ma, mb, t;
      for (int i = 0; i < 3; i++) begin
         dp[i] = longint'(pt[i]) - longint'($signed(centre[i]));
         dc[i] = longint'(pt[i+3]) - longint'($signed(centre[i]));
      end
      unit_axis(axis_reg[0], nu);
      unit_axis(axis_reg[1], ru);
      unit_axis(axis_reg[2], uu);
      a = project(dp, nu);
      b = project(dc, nu);
      eps = margin;
      if (!((a > eps && b < -eps) || (a < -eps && b > eps))) return 1'b0;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      t = (ma << T_BITS) / (ma + mb);
      lx = lerp(project(dp, ru), project(dc, ru), t);
      ly = lerp(project(dp, uu), project(dc, uu), t);
      return fits(lx, size_wh[30:0]) && fits(ly, size_wh[61:31]);
   endfunction

   // ---------------------------------------------------------------- drivers
   // Offer one item, hold it until taken, then record its expectation
   task automatic send_segment(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               bit no_gap = 1'b0);
      logic signed [31:0] pt [6];
      int gap;
      pt = '{px, py, pz, cx, cy, cz};
      req.valid  <= 1'b1;
      req.prev_x <= px; req.prev_y <= py; req.prev_z <= pz;
      req.cur_x  <= cx; req.cur_y  <= cy; req.cur_z  <= cz;
      do @(posedge clock); while (!req.ready);
      crossing_q.push_back(predict_crossing(pt));
      gap = 0;
      if (!no_gap) begin
         case ($urandom_range(0, 19))
            0:             gap = $urandom_range(10, 40);
            1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
            default:       gap = 0;
         endcase
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic end_burst();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Let the block drain before touching a register
   task automatic quiesce();
      while (crossing_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << CSR_IDX_LSB;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_CENTRE_X:    centre[0]   = value[31:0];
         REG_CENTRE_Y:    centre[1]   = value[31:0];
         REG_CENTRE_Z:    centre[2]   = value[31:0];
         REG_NORMAL_DIR:  axis_reg[0] = value[62:0];
         REG_RIGHT_DIR:   axis_reg[1] = value[62:0];
         REG_UP_DIR:      axis_reg[2] = value[62:0];
         REG_SIZE_WH:     size_wh     = value[61:0];
         REG_SIDE_MARGIN: margin      = value[30:0];
         default: ;
      endcase
   endtask

   function automatic logic [62:0] pack_axis(int x, int y, int z);
      logic [62:0] p;
      p = '0;
      p[20:0]  = x[20:0];
      p[41:21] = y[20:0];
      p[62:42] = z[20:0];
      return p;
   endfunction

   function automatic logic [61:0] pack_size(logic [30:0] w, logic [30:0] h);
      return {h, w};
   endfunction

   task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [62:0] n, logic [62:0] r, logic [62:0] u,
                            logic [61:0] sz, logic [30:0] eps);
      write_reg(REG_CENTRE_X, cx);
      write_reg(REG_CENTRE_Y, cy);
      write_reg(REG_CENTRE_Z, cz);
      write_reg(REG_NORMAL_DIR, n);
      write_reg(REG_RIGHT_DIR, r);
      write_reg(REG_UP_DIR, u);
      write_reg(REG_SIZE_WH, sz);
      write_reg(REG_SIDE_MARGIN, eps);
   endtask

   function automatic int rand_comp();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(1, 64) * ($urandom_range(0, 1) ? 1 : -1);
         2:       return $urandom_range(0, 1) ? -(1 << 20) : (1 << 20) - 1;
         default: return int'($urandom_range(0, (1 << 21) - 1)) - (1 << 20);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests
   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] MINV = 32'h8000_0000;
   localparam logic [31:0] MAXV = 32'h7fff_ffff;

   task automatic test_directed();
      // Axis-aligned portal 20 x 10 in the xy plane, margin 1.0
      write_all(0, 0, 0, pack_axis(0, 0, 1 << 19), pack_axis(1 << 19, 0, 0),
                pack_axis(0, 1 << 19, 0), pack_size(31'(20 * ONE), 31'(10 * ONE)), ONE);
      quiesce();
      send_segment(0, 0, 2 * ONE, 0, 0, -2 * ONE);
      send_segment(0, 0, -2 * ONE, 0, 0, 2 * ONE);
      send_segment(15 * ONE, 0, 2 * ONE, 15 * ONE, 0, -2 * ONE);
      send_segment(10 * ONE, 5 * ONE, 3 * ONE, 10 * ONE, 5 * ONE, -3 * ONE);
      send_segment(10 * ONE + 1, 0, 3 * ONE, 10 * ONE + 1, 0, -3 * ONE);
      send_segment(0, 0, ONE, 0, 0, -2 * ONE);       // touching the margin
      send_segment(0, 0, 2 * ONE, 0, 0, -ONE);
      send_segment(0, 0, ONE + 1, 0, 0, -ONE - 1);
      send_segment(MINV, MINV, MINV, MAXV, MAXV, MAXV);
      send_segment(MAXV, MAXV, MAXV, MINV, MINV, MINV);
      send_segment(0, 0, MAXV, 0, 0, MINV);
      send_segment(MAXV, MINV, MAXV, MINV, MAXV, MINV);
      end_burst();
      quiesce();
      // Zero normal never crosses
      write_reg(REG_NORMAL_DIR, '0);
      quiesce();
      send_segment(0, 0, 2 * ONE, 0, 0, -2 * ONE);
      send_segment(0, 0, MAXV, 0, 0, MINV);
      end_burst();
      quiesce();
      // Zero right and up axes always pass their bound
      write_all(0, 0, 0, pack_axis(0, 0, -1), '0, '0, '0, '0);
      quiesce();
      send_segment(MAXV, MINV, 5 * ONE, MINV, MAXV, -5 * ONE);
      send_segment(0, 0, 1, 0, 0, -1);
      end_burst();
      quiesce();
      // Extreme register values
      write_all(MINV, MAXV, MINV, pack_axis(-(1 << 20), (1 << 20) - 1, -(1 << 20)),
                {63{1'b1}}, pack_axis(1, -1, 0), {62{1'b1}}, 31'h7fff_ffff);
      quiesce();
      send_segment(MAXV, MINV, MAXV, MINV, MAXV, MINV);
      send_segment(MINV, MINV, MINV, MAXV, MAXV, MAXV);
      end_burst();
      quiesce();
      write_reg(REG_SIDE_MARGIN, '0);
      quiesce();
      send_segment(MAXV, MINV, MAXV, MINV, MAXV, MINV);
      send_segment(0, 0, 0, 1, 1, 1);
      end_burst();
      quiesce();
   endtask

   // Random portals; most segment coordinates lie within a random span of the portal centre
   task automatic test_random_portals(int sets, int per_set);
      logic [31:0] p [6];
      logic [31:0] span;
      for (int s = 0; s < sets; s++) begin
         write_all($urandom(), $urandom(), $urandom(),
                   pack_axis(rand_comp(), rand_comp(), rand_comp()),
                   pack_axis(rand_comp(), rand_comp(), rand_comp()),
                   pack_axis(rand_comp(), rand_comp(), rand_comp()),
                   pack_size(31'($urandom_range(0, 1 << 23)),
                             31'($urandom_range(0, 1 << 23))),
                   $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 1 << 16)));
         quiesce();
         for (int k = 0; k < per_set; k++) begin
            span = 32'd1 << $urandom_range(4, 22);
            for (int i = 0; i < 6; i++) begin
               if ($urandom_range(0, 9) < 7)
                  p[i] = centre[i % 3] + $urandom_range(0, 2 * span) - span;
               else
                  p[i] = $urandom();
            end
            send_segment(p[0], p[1], p[2], p[3], p[4], p[5]);
         end
         end_burst();
         quiesce();
      end
   endtask

   // Receiver stalls for a long stretch while items keep coming
   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int k = 0; k < 60; k++)
         send_segment(centre[0] + $urandom_range(0, 1 << 18), centre[1], $urandom(),
                      centre[0], centre[1] + $urandom_range(0, 1 << 18), $urandom(),
                      1'b1);
      end_burst();
      quiesce();
   endtask

   // ---------------------------------------------------------------- receiver
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0:          gap = $urandom_range(10, 40);
               1, 2, 3, 4: gap = $urandom_range(1, 3);
               default:    gap = 0;
            endcase
            if (gap > 0) begin
               rsp.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(0, 8)) @(posedge clock);
         end
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (crossing_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result crosses=%0b", rsp.crosses);
         end else begin
            want = crossing_q.pop_front();
            if (rsp.crosses !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("crosses mismatch: expected %0b, got %0b", want, rsp.crosses);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_portals(8, 125);
      test_backpressure();
      while (crossing_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && crossing_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end
endmodule
